[hdl/dq_pkg.sv]
// Shared types, constants and helpers for the double-ended queue.
// Used by dq_ram and double_ended_queue; depends on nothing else.
package dq_pkg;

   // Capacity and derived widths
   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int IDX_W  = 8;
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int WORD_W = 64;
   localparam int CMD_W  = 3;
   localparam int OCNT_W = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] value;
      logic [IDX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [OCNT_W-1:0] count;
      logic              miss;
      logic              refused;
   } rsp_type;

   // Physical slot at a logical offset from the head; the sum stays below 2*DEPTH
   function automatic logic [ADDR_W-1:0] slot_at(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0]  offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

[hdl/dq_ram.sv]
// Word storage of the queue: one write port, one registered read port.
// Depends on dq_pkg for DEPTH and widths.
module dq_ram
   import dq_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Write the pushed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word; it appears in the cycle after its address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/double_ended_queue.sv]
// Top level of the double-ended queue: head/count bookkeeping around dq_ram.
// Depends on dq_pkg and dq_ram.
//
//   channel   ports                      handshake
//   request   start, busy, req           taken when start is high and busy low
//   response  rsp_strobe, rsp            one cycle per transaction, no backpressure
//
// One transaction is taken every cycle; its response appears on the cycle
// after it is taken, since the read port of the storage RAM is registered.
// busy stays low, so commands may follow each other back to back.
// Synchronous reset empties the queue (head and count to zero); storage keeps
// its contents and needs no clearing pass.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              strobe_ff;
   logic              hit_ff, hit_in;
   logic              miss_ff, miss_in;
   logic              refused_ff, refused_in;
   logic [OCNT_W-1:0] ocount_ff;

   logic              accept;
   logic              full;
   logic              empty;
   logic [CMP_W-1:0]  idx_wide;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign idx_wide = CMP_W'(req.index);

   // Decode the command: pick the slot, update head and count
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_at(head_ff, count_ff);
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      hit_in     = 1'b0;
      miss_in    = 1'b0;
      refused_in = 1'b0;
      if (accept) begin
         unique case (req.command)
            CMD_PUSH_BACK: begin
               if (full) begin
                  refused_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_PUSH_FRONT: begin
               if (full) begin
                  refused_in = 1'b1;
               end else begin
                  head_in  = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - 1'b1;
                  wr_en    = 1'b1;
                  wr_addr  = head_in;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  miss_in = 1'b1;
               end else begin
                  count_in = count_ff - 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = slot_at(head_ff, count_in);
                  hit_in   = 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  miss_in = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  hit_in   = 1'b1;
                  head_in  = slot_at(head_ff, CNT_W'(1));
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_READ: begin
               if (idx_wide >= CMP_W'(count_ff)) begin
                  miss_in = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_at(head_ff, idx_wide[CNT_W-1:0]);
                  hit_in  = 1'b1;
               end
            end
            CMD_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
               // unknown command: hold state, report current count
            end
         endcase
      end
   end

   // Advance bookkeeping and register the response flags
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         strobe_ff  <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         strobe_ff  <= accept;
         hit_ff     <= hit_in;
      end
      miss_ff    <= miss_in;
      refused_ff <= refused_in;
      ocount_ff  <= OCNT_W'(count_in);
   end

   dq_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Drive the response; data is zero unless a word was read
   assign rsp_strobe  = strobe_ff;
   assign rsp.data    = hit_ff ? rd_data : '0;
   assign rsp.count   = ocount_ff;
   assign rsp.miss    = miss_ff;
   assign rsp.refused = refused_ff;

endmodule
